[design/tca_pkg.sv]
// Shared constants, types and helpers of the two-class alternating arbiter.
package tca_pkg;

  // Waiter queue depth per category, and the widths that follow from it
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW      = $clog2(2 * QueueDepth);
  localparam int unsigned IdW        = 8;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OWN_FREE = 2'd0,
    OWN_CAT0 = 2'd1,
    OWN_CAT1 = 2'd2
  } owner_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_FREE_REL  = 2'd2
  } err_e;

  // One result beat
  typedef struct packed {
    logic           grant_valid;
    logic [IdW-1:0] grant_id;
    logic           grant_category;
    logic [1:0]     owner_after;
    logic [1:0]     error_code;
  } res_t;

  // Result hand-off from control to the output register
  typedef struct packed {
    logic load;
    logic from_ram;
    res_t res;
  } res_load_t;

  // Waiter memory access
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [IdW-1:0]   wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  // Ring pointer advance, wraps at the queue depth
  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Category 0 lives in the lower half of the memory, category 1 above it
  function automatic logic [AddrW-1:0] qaddr(logic c, logic [PtrW-1:0] p);
    return c ? (AddrW'(p) + AddrW'(QueueDepth)) : AddrW'(p);
  endfunction

endpackage

[design/tca_req_if.sv]
// Request/release input channel.
interface tca_req_if;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic                    category;
  logic [tca_pkg::IdW-1:0] requester_id;

  modport source (output valid, command, category, requester_id, input ready);
  modport sink   (input valid, command, category, requester_id, output ready);
endinterface

[design/tca_res_if.sv]
// Grant result output channel.
interface tca_res_if;
  logic                    valid;
  logic                    ready;
  logic                    grant_valid;
  logic [tca_pkg::IdW-1:0] grant_id;
  logic                    grant_category;
  logic [1:0]              owner_after;
  logic [1:0]              error_code;

  modport source (output valid, grant_valid, grant_id, grant_category, owner_after,
                  error_code, input ready);
  modport sink   (input valid, grant_valid, grant_id, grant_category, owner_after,
                  error_code, output ready);
endinterface

[design/tca_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/tca_ctrl.sv]
// Arbitration control: owner, queue pointers, counts and waiter memory access.
module tca_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    command_i,
  input  logic                    category_i,
  input  logic [tca_pkg::IdW-1:0] requester_id_i,
  output logic                    busy_o,
  output tca_pkg::ram_req_t       ram_o,
  output tca_pkg::res_load_t      load_o
);

  tca_pkg::owner_e                owner_q, owner_d;
  logic [tca_pkg::PtrW-1:0]       head_q [2];
  logic [tca_pkg::PtrW-1:0]       head_d [2];
  logic [tca_pkg::PtrW-1:0]       tail_q [2];
  logic [tca_pkg::PtrW-1:0]       tail_d [2];
  logic [tca_pkg::CntW-1:0]       cnt_q  [2];
  logic [tca_pkg::CntW-1:0]       cnt_d  [2];
  logic                           pend_q, pend_d;
  tca_pkg::res_t                  pend_res_q, pend_res_d;
  tca_pkg::res_t                  imm_res;
  logic                           pop;
  logic                           cur, other, pop_cat;
  logic                           own_valid;

  assign cur = (owner_q == tca_pkg::OWN_CAT1);
  assign other = ~cur;

  // Decide the item, update pointers and counts at acceptance
  always_comb begin
    owner_d    = owner_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    pend_res_d = pend_res_q;
    pop        = 1'b0;
    pop_cat    = 1'b0;
    ram_o      = '0;
    imm_res    = '0;
    own_valid  = 1'b0;

    unique case (owner_q)
      tca_pkg::OWN_CAT0, tca_pkg::OWN_CAT1: own_valid = 1'b1;
      default:                              own_valid = 1'b0;
    endcase

    if (accept_i) begin
      unique case (tca_pkg::cmd_e'(command_i))
        tca_pkg::CMD_REQUEST: begin
          if (owner_q == tca_pkg::OWN_FREE) begin
            // Free resource: grant at once
            owner_d                = category_i ? tca_pkg::OWN_CAT1 : tca_pkg::OWN_CAT0;
            imm_res.grant_valid    = 1'b1;
            imm_res.grant_id       = requester_id_i;
            imm_res.grant_category = category_i;
          end else if (cnt_q[category_i] == tca_pkg::CntW'(tca_pkg::QueueDepth)) begin
            imm_res.error_code = tca_pkg::ERR_FULL;
          end else begin
            // Queue the waiter at its category's tail
            ram_o.we              = 1'b1;
            ram_o.waddr           = tca_pkg::qaddr(category_i, tail_q[category_i]);
            ram_o.wdata           = requester_id_i;
            tail_d[category_i]    = tca_pkg::bump(tail_q[category_i]);
            cnt_d[category_i]     = cnt_q[category_i] + tca_pkg::CntW'(1);
          end
        end
        tca_pkg::CMD_RELEASE: begin
          if (!own_valid) begin
            imm_res.error_code = tca_pkg::ERR_FREE_REL;
          end else if (cnt_q[other] != '0) begin
            pop     = 1'b1;
            pop_cat = other;
            owner_d = other ? tca_pkg::OWN_CAT1 : tca_pkg::OWN_CAT0;
          end else if (cnt_q[cur] != '0) begin
            pop     = 1'b1;
            pop_cat = cur;
          end else begin
            owner_d = tca_pkg::OWN_FREE;
          end
        end
        default: ;
      endcase
    end

    // Oldest waiter leaves: read its entry, result completes next cycle
    if (pop) begin
      ram_o.re                  = 1'b1;
      ram_o.raddr               = tca_pkg::qaddr(pop_cat, head_q[pop_cat]);
      head_d[pop_cat]           = tca_pkg::bump(head_q[pop_cat]);
      cnt_d[pop_cat]            = cnt_q[pop_cat] - tca_pkg::CntW'(1);
      pend_d                    = 1'b1;
      pend_res_d                = '0;
      pend_res_d.grant_valid    = 1'b1;
      pend_res_d.grant_category = pop_cat;
      pend_res_d.owner_after    = owner_d;
    end

    imm_res.owner_after = owner_d;
  end

  // Result hand-off
  always_comb begin
    load_o.load     = (accept_i && !pop) || pend_q;
    load_o.from_ram = pend_q;
    load_o.res      = pend_q ? pend_res_q : imm_res;
  end

  assign busy_o = pend_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= tca_pkg::OWN_FREE;
      head_q  <= '{default: '0};
      tail_q  <= '{default: '0};
      cnt_q   <= '{default: '0};
      pend_q  <= 1'b0;
    end else begin
      owner_q <= owner_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // Pending result fields
  always_ff @(posedge clk_i) begin
    pend_res_q <= pend_res_d;
  end

endmodule

[design/two_class_alternating_arbiter_top.sv]
// Top level of the two-class alternating arbiter.
//
// Usage: req_i carries request/release beats (command, category,
// requester_id); res_o returns exactly one result beat per accepted input
// beat, in order. A request takes the free resource at once, otherwise
// waits in its category's queue; a release hands over to the oldest
// waiter of the other category first, then of the same category, else
// frees the resource. Full queues and releases while free are flagged.
// Timing: the result is registered and shows the cycle after acceptance;
// a release that hands over to a waiter reads the waiter memory, so its
// result passes the memory's read register, then the output register.
// Throughput: one beat per cycle unless res_o stalls; a handing-over
// release holds the input (busy) while the memory read completes.
// Reset: the resource is free and both queues are empty; queue memory
// contents are not cleared, so no clearing pass is needed.
// Stall: while res_o is stalled with a result held, req_i is not ready
// unless that result is taken in the same cycle.
module two_class_alternating_arbiter_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  tca_req_if.sink       req_i,
  tca_res_if.source     res_o
);

  logic                      accept;
  logic                      busy;
  tca_pkg::ram_req_t         ram_req;
  tca_pkg::res_load_t        load;
  logic [tca_pkg::IdW-1:0]   rdata;
  logic                      out_valid_q, out_valid_d;
  tca_pkg::res_t             out_res_q, out_res_d;

  // Input handshake
  assign req_i.ready = !busy && (!out_valid_q || res_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  tca_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (req_i.command),
    .category_i     (req_i.category),
    .requester_id_i (req_i.requester_id),
    .busy_o         (busy),
    .ram_o          (ram_req),
    .load_o         (load)
  );

  tca_ram #(
    .Width (tca_pkg::IdW),
    .Depth (2 * tca_pkg::QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load.load) begin
      out_valid_d = 1'b1;
      out_res_d   = load.res;
      if (load.from_ram) begin
        out_res_d.grant_id = rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.grant_valid    = out_res_q.grant_valid;
  assign res_o.grant_id       = out_res_q.grant_id;
  assign res_o.grant_category = out_res_q.grant_category;
  assign res_o.owner_after    = out_res_q.owner_after;
  assign res_o.error_code     = out_res_q.error_code;

endmodule
